/* rtl/sit_pkg.sv */
// Package for the segment intersection test pipeline.
// Holds coordinate widths and the structs passed between stages; no dependencies.
`default_nettype none

package sit_pkg;

   localparam int COORD_BITS = 16;
   // difference of two coordinates
   localparam int DIFF_BITS  = COORD_BITS + 1;
   // product of two differences
   localparam int PROD_BITS  = 2 * DIFF_BITS;
   // difference of two products
   localparam int NUM_BITS   = PROD_BITS + 1;
   // numerators after a conditional negate
   localparam int ABS_BITS   = NUM_BITS + 1;

   typedef struct packed {
      logic signed [DIFF_BITS-1:0] dxa;
      logic signed [DIFF_BITS-1:0] dya;
      logic signed [DIFF_BITS-1:0] dxb;
      logic signed [DIFF_BITS-1:0] dyb;
      logic signed [DIFF_BITS-1:0] dxs;
      logic signed [DIFF_BITS-1:0] dys;
   } diff_type;

   typedef struct packed {
      logic signed [PROD_BITS-1:0] det_pos;
      logic signed [PROD_BITS-1:0] det_neg;
      logic signed [PROD_BITS-1:0] t_pos;
      logic signed [PROD_BITS-1:0] t_neg;
      logic signed [PROD_BITS-1:0] u_pos;
      logic signed [PROD_BITS-1:0] u_neg;
   } prod_type;

   typedef struct packed {
      logic signed [NUM_BITS-1:0] det;
      logic signed [NUM_BITS-1:0] t_num;
      logic signed [NUM_BITS-1:0] u_num;
   } num_type;

endpackage

`default_nettype wire

/* rtl/sit_front.sv */
// First two pipeline stages: coordinate differences, then the six cross products.
// Depends on sit_pkg.
`default_nettype none

module sit_front
   import sit_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic                         in_valid,
   input  wire logic signed [COORD_BITS-1:0] a_start_x,
   input  wire logic signed [COORD_BITS-1:0] a_start_y,
   input  wire logic signed [COORD_BITS-1:0] a_end_x,
   input  wire logic signed [COORD_BITS-1:0] a_end_y,
   input  wire logic signed [COORD_BITS-1:0] b_start_x,
   input  wire logic signed [COORD_BITS-1:0] b_start_y,
   input  wire logic signed [COORD_BITS-1:0] b_end_x,
   input  wire logic signed [COORD_BITS-1:0] b_end_y,
   output logic                              out_valid,
   output prod_type                          out_prod
);

   diff_type diff_in, diff_ff;
   prod_type prod_in, prod_ff;
   logic     diff_valid_ff;
   logic     prod_valid_ff;

   always_comb begin
      diff_in.dxa = DIFF_BITS'(a_start_x) - DIFF_BITS'(a_end_x);
      diff_in.dya = DIFF_BITS'(a_start_y) - DIFF_BITS'(a_end_y);
      diff_in.dxb = DIFF_BITS'(b_start_x) - DIFF_BITS'(b_end_x);
      diff_in.dyb = DIFF_BITS'(b_start_y) - DIFF_BITS'(b_end_y);
      diff_in.dxs = DIFF_BITS'(a_start_x) - DIFF_BITS'(b_start_x);
      diff_in.dys = DIFF_BITS'(a_start_y) - DIFF_BITS'(b_start_y);
   end

   always_comb begin
      prod_in.det_pos = PROD_BITS'(diff_ff.dxa) * PROD_BITS'(diff_ff.dyb);
      prod_in.det_neg = PROD_BITS'(diff_ff.dya) * PROD_BITS'(diff_ff.dxb);
      prod_in.t_pos   = PROD_BITS'(diff_ff.dxs) * PROD_BITS'(diff_ff.dyb);
      prod_in.t_neg   = PROD_BITS'(diff_ff.dys) * PROD_BITS'(diff_ff.dxb);
      prod_in.u_pos   = PROD_BITS'(diff_ff.dya) * PROD_BITS'(diff_ff.dxs);
      prod_in.u_neg   = PROD_BITS'(diff_ff.dxa) * PROD_BITS'(diff_ff.dys);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else if (advance) begin
         diff_valid_ff <= in_valid;
         prod_valid_ff <= diff_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         diff_ff <= diff_in;
         prod_ff <= prod_in;
      end
   end

   assign out_valid = prod_valid_ff;
   assign out_prod  = prod_ff;

endmodule

`default_nettype wire

/* rtl/sit_sum.sv */
// Third pipeline stage: determinant and both parameter numerators.
// Depends on sit_pkg.
`default_nettype none

module sit_sum
   import sit_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire logic     in_valid,
   input  wire prod_type in_prod,
   output logic          out_valid,
   output num_type       out_num
);

   num_type num_in, num_ff;
   logic    num_valid_ff;

   always_comb begin
      num_in.det   = NUM_BITS'(in_prod.det_pos) - NUM_BITS'(in_prod.det_neg);
      num_in.t_num = NUM_BITS'(in_prod.t_pos) - NUM_BITS'(in_prod.t_neg);
      num_in.u_num = NUM_BITS'(in_prod.u_pos) - NUM_BITS'(in_prod.u_neg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_valid_ff <= 1'b0;
      end else if (advance) begin
         num_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         num_ff <= num_in;
      end
   end

   assign out_valid = num_valid_ff;
   assign out_num   = num_ff;

endmodule

`default_nettype wire

/* rtl/sit_decide.sv */
// Last two pipeline stages: sign normalization, then the range compares.
// Depends on sit_pkg; its final registers drive the result channel.
`default_nettype none

module sit_decide
   import sit_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     advance,
   input  wire logic     in_valid,
   input  wire num_type  in_num,
   output logic          out_valid,
   output logic          out_crosses,
   output logic          out_parallel
);

   logic signed [ABS_BITS-1:0] det_ext;
   logic signed [ABS_BITS-1:0] t_ext;
   logic signed [ABS_BITS-1:0] u_ext;
   logic signed [ABS_BITS-1:0] den_in, den_ff;
   logic signed [ABS_BITS-1:0] t_in, t_ff;
   logic signed [ABS_BITS-1:0] u_in, u_ff;
   logic                       zero_in, zero_ff;
   logic                       norm_valid_ff;
   logic                       crosses_in, crosses_ff;
   logic                       parallel_ff;
   logic                       valid_ff;

   // negate everything for a negative determinant so the compares run one way
   always_comb begin
      det_ext = ABS_BITS'(in_num.det);
      t_ext   = ABS_BITS'(in_num.t_num);
      u_ext   = ABS_BITS'(in_num.u_num);
      zero_in = (in_num.det == '0);
      if (in_num.det[NUM_BITS-1]) begin
         den_in = -det_ext;
         t_in   = -t_ext;
         u_in   = -u_ext;
      end else begin
         den_in = det_ext;
         t_in   = t_ext;
         u_in   = u_ext;
      end
   end

   always_comb begin
      crosses_in = !zero_ff
                   && !t_ff[ABS_BITS-1] && (t_ff <= den_ff)
                   && !u_ff[ABS_BITS-1] && (u_ff <= den_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         norm_valid_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else if (advance) begin
         norm_valid_ff <= in_valid;
         valid_ff      <= norm_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den_ff      <= den_in;
         t_ff        <= t_in;
         u_ff        <= u_in;
         zero_ff     <= zero_in;
         crosses_ff  <= crosses_in;
         parallel_ff <= zero_ff;
      end
   end

   assign out_valid    = valid_ff;
   assign out_crosses  = crosses_ff;
   assign out_parallel = parallel_ff;

endmodule

`default_nettype wire

/* rtl/segment_intersection_test.sv */
// Segment intersection test: one pair of segments in, one crosses/parallel result out.
// The five-stage pipeline takes a new item every cycle while the result side is not
// stalled. The whole pipeline advances together, so a stall on the result channel
// stalls the request channel in the same cycle (req_stall follows rsp_stall while a
// result is held). The stages are coordinate differences, six cross products, the
// determinant and numerators, sign normalization, and the range compares. A zero
// determinant reports parallel and never crosses. Depends on sit_pkg, sit_front,
// sit_sum and sit_decide.
`default_nettype none

module segment_intersection_test
   import sit_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic signed [COORD_BITS-1:0] req_seg_a_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_a_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_seg_a_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_a_end_y,
   input  wire logic signed [COORD_BITS-1:0] req_seg_b_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_b_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_seg_b_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_seg_b_end_y,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic                              rsp_crosses,
   output logic                              rsp_parallel
);

   logic     advance;
   logic     prod_valid;
   prod_type prod;
   logic     num_valid;
   num_type  num;

   // hold every stage while a finished result waits
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   sit_front u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .a_start_x (req_seg_a_start_x),
      .a_start_y (req_seg_a_start_y),
      .a_end_x   (req_seg_a_end_x),
      .a_end_y   (req_seg_a_end_y),
      .b_start_x (req_seg_b_start_x),
      .b_start_y (req_seg_b_start_y),
      .b_end_x   (req_seg_b_end_x),
      .b_end_y   (req_seg_b_end_y),
      .out_valid (prod_valid),
      .out_prod  (prod)
   );

   sit_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (prod_valid),
      .in_prod   (prod),
      .out_valid (num_valid),
      .out_num   (num)
   );

   sit_decide u_decide (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .in_valid     (num_valid),
      .in_num       (num),
      .out_valid    (rsp_valid),
      .out_crosses  (rsp_crosses),
      .out_parallel (rsp_parallel)
   );

`ifndef SYNTHESIS
   a_parallel_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_parallel |-> !rsp_crosses)
      else $error("parallel result also reports a crossing");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("request taken while a result is held");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

/* sim/segment_intersection_test_tb.sv */
// Self-checking testbench for segment_intersection_test: directed and random segment pairs.
// Runs its own exact integer crossing predictor and a scoreboard class.
// Depends on sit_pkg and the segment_intersection_test RTL only.

typedef logic signed [sit_pkg::COORD_BITS-1:0] coord_type;

typedef struct packed {
   coord_type ax0;
   coord_type ay0;
   coord_type ax1;
   coord_type ay1;
   coord_type bx0;
   coord_type by0;
   coord_type bx1;
   coord_type by1;
} seg_pair_type;

typedef struct packed {
   logic crosses;
   logic parallel;
} verdict_type;

class crossing_scoreboard;
   verdict_type verdict_q[$];
   int          errors;

   function new();
      errors = 0;
   endfunction

   // true when num/den lies in [0, 1]; den is nonzero
   static function bit in_unit_range(longint num, longint den);
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      return num >= 0 && num <= den;
   endfunction

   static function verdict_type crossing_of(seg_pair_type s);
      longint      dxa, dya, dxb, dyb, dxs, dys, det, t_num, u_num;
      verdict_type v;
      dxa = longint'($signed(s.ax0)) - longint'($signed(s.ax1));
      dya = longint'($signed(s.ay0)) - longint'($signed(s.ay1));
      dxb = longint'($signed(s.bx0)) - longint'($signed(s.bx1));
      dyb = longint'($signed(s.by0)) - longint'($signed(s.by1));
      dxs = longint'($signed(s.ax0)) - longint'($signed(s.bx0));
      dys = longint'($signed(s.ay0)) - longint'($signed(s.by0));
      det = dxa * dyb - dya * dxb;
      if (det == 0) begin
         v.crosses  = 1'b0;
         v.parallel = 1'b1;
      end else begin
         t_num      = dxs * dyb - dys * dxb;
         u_num      = dya * dxs - dxa * dys;
         v.crosses  = in_unit_range(t_num, det) && in_unit_range(u_num, det);
         v.parallel = 1'b0;
      end
      return v;
   endfunction

   function void note_request(seg_pair_type s);
      verdict_q.push_back(crossing_of(s));
   endfunction

   function void check_result(logic crosses, logic parallel);
      verdict_type want;
      if (verdict_q.size() == 0) begin
         $error("result with no item outstanding: crosses %0b parallel %0b",
                crosses, parallel);
         errors++;
         return;
      end
      want = verdict_q.pop_front();
      if (crosses !== want.crosses) begin
         $error("crosses: expected %0b, got %0b", want.crosses, crosses);
         errors++;
      end
      if (parallel !== want.parallel) begin
         $error("parallel: expected %0b, got %0b", want.parallel, parallel);
         errors++;
      end
   endfunction

   function int pending();
      return verdict_q.size();
   endfunction
endclass

module segment_intersection_test_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   coord_type req_seg_a_start_x, req_seg_a_start_y, req_seg_a_end_x, req_seg_a_end_y;
   coord_type req_seg_b_start_x, req_seg_b_start_y, req_seg_b_end_x, req_seg_b_end_y;
   logic      rsp_valid;
   logic      rsp_stall;
   logic      rsp_crosses;
   logic      rsp_parallel;

   int        req_idle_pct  = 0;
   int        rsp_stall_pct = 0;
   int        hold_left     = 0;

   crossing_scoreboard sb = new();

   segment_intersection_test uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_seg_a_start_x (req_seg_a_start_x),
      .req_seg_a_start_y (req_seg_a_start_y),
      .req_seg_a_end_x   (req_seg_a_end_x),
      .req_seg_a_end_y   (req_seg_a_end_y),
      .req_seg_b_start_x (req_seg_b_start_x),
      .req_seg_b_start_y (req_seg_b_start_y),
      .req_seg_b_end_x   (req_seg_b_end_x),
      .req_seg_b_end_y   (req_seg_b_end_y),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_crosses       (rsp_crosses),
      .rsp_parallel      (rsp_parallel)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // receiver: a long hold-off when requested, otherwise random stalls
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // both handshakes are sampled at the edge, before any update lands
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_crosses, rsp_parallel);
         if (req_valid && !req_stall)
            sb.note_request({req_seg_a_start_x, req_seg_a_start_y,
                             req_seg_a_end_x, req_seg_a_end_y,
                             req_seg_b_start_x, req_seg_b_start_y,
                             req_seg_b_end_x, req_seg_b_end_y});
      end
   end

   function automatic seg_pair_type pair_of(int ax0, int ay0, int ax1, int ay1,
                                            int bx0, int by0, int bx1, int by1);
      seg_pair_type s;
      s.ax0 = coord_type'(ax0);
      s.ay0 = coord_type'(ay0);
      s.ax1 = coord_type'(ax1);
      s.ay1 = coord_type'(ay1);
      s.bx0 = coord_type'(bx0);
      s.by0 = coord_type'(by0);
      s.bx1 = coord_type'(bx1);
      s.by1 = coord_type'(by1);
      return s;
   endfunction

   function automatic int pick(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   function automatic seg_pair_type random_pair();
      int           mode, px, py, dx, dy, ex, ey, k, j, a1, a2, b1, b2;
      seg_pair_type s;
      mode = pick(0, 99);
      if (mode < 35) begin
         s = seg_pair_type'({$urandom, $urandom, $urandom, $urandom});
      end else if (mode < 60) begin
         // tiny grid: many touches at the bounds and many zero determinants
         s = pair_of(pick(-6, 6), pick(-6, 6), pick(-6, 6), pick(-6, 6),
                     pick(-6, 6), pick(-6, 6), pick(-6, 6), pick(-6, 6));
      end else if (mode < 78) begin
         // parallel or collinear by construction
         px = pick(-1000, 1000);
         py = pick(-1000, 1000);
         dx = pick(-50, 50);
         dy = pick(-50, 50);
         k  = pick(-3, 3);
         j  = pick(-2, 2);
         if (pick(0, 1) == 1) begin
            ex = px + j * dx;
            ey = py + j * dy;
         end else begin
            ex = pick(-1000, 1000);
            ey = pick(-1000, 1000);
         end
         s = pair_of(px, py, px + dx, py + dy, ex, ey, ex + k * dx, ey + k * dy);
      end else begin
         // two segments through a common point, which may sit on an end
         px = pick(-30000, 30000);
         py = pick(-30000, 30000);
         dx = pick(-50, 50);
         dy = pick(-50, 50);
         ex = pick(-50, 50);
         ey = pick(-50, 50);
         a1 = pick(0, 3);
         a2 = pick(0, 3);
         b1 = pick(0, 3);
         b2 = pick(0, 3);
         s = pair_of(px - a1 * dx, py - a1 * dy, px + a2 * dx, py + a2 * dy,
                     px - b1 * ex, py - b1 * ey, px + b2 * ex, py + b2 * ey);
      end
      return s;
   endfunction

   task automatic send_pair(seg_pair_type s);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_seg_a_start_x <= s.ax0;
      req_seg_a_start_y <= s.ay0;
      req_seg_a_end_x   <= s.ax1;
      req_seg_a_end_y   <= s.ay1;
      req_seg_b_start_x <= s.bx0;
      req_seg_b_start_y <= s.by0;
      req_seg_b_end_x   <= s.bx1;
      req_seg_b_end_y   <= s.by1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   // drop valid and hold until every outstanding item has its result;
   // wait for a clock edge first so the last accepted item is already noted
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0)
         @(posedge clock);
   endtask

   task automatic random_phase(int idle_pct, int stall_pct, int hold, int count);
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      hold_left     = hold;
      repeat (count)
         send_pair(random_pair());
      drain();
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_seg_a_start_x <= '0;
      req_seg_a_start_y <= '0;
      req_seg_a_end_x   <= '0;
      req_seg_a_end_y   <= '0;
      req_seg_b_start_x <= '0;
      req_seg_b_start_y <= '0;
      req_seg_b_end_x   <= '0;
      req_seg_b_end_y   <= '0;
      repeat (4)
         @(posedge clock);
      reset <= 1'b0;

      send_pair(pair_of(0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(pair_of(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
      send_pair(pair_of(-32768, -32768, 32767, -32768, -32768, -32768, -32768, 32767));
      send_pair(pair_of(32767, -32768, -32768, -32768, -32768, -32768, -32768, 32767));
      send_pair(pair_of(-32768, 32767, 32767, 32767, 32767, 32767, 32767, -32768));
      send_pair(pair_of(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
      send_pair(pair_of(-1, -1, -1, -1, -1, -1, -1, -1));
      send_pair(pair_of(0, 0, 10, 0, 10, -5, 10, 5));
      send_pair(pair_of(0, 0, 10, 0, 11, -5, 11, 5));
      send_pair(pair_of(0, 0, 10, 0, 0, -5, 0, 5));
      send_pair(pair_of(0, 0, 10, 0, -1, -5, -1, 5));
      send_pair(pair_of(0, 0, 10, 0, 5, 0, 5, 7));
      send_pair(pair_of(0, 0, 10, 0, 5, 1, 5, 7));
      send_pair(pair_of(10, 0, 0, 0, 5, 5, 5, -5));
      send_pair(pair_of(0, 0, 10, 0, 5, 0, 15, 0));
      send_pair(pair_of(0, 0, 10, 0, 20, 0, 30, 0));
      send_pair(pair_of(0, 0, 10, 10, 0, 1, 10, 11));
      send_pair(pair_of(0, 0, 10, 0, 5, 0, 5, 0));
      send_pair(pair_of(7, 7, 7, 7, -3, -3, -3, -3));
      send_pair(pair_of(0, 0, 1, 1, 10, 0, 9, 1));
      drain();

      // the first phase opens with a long hold-off so the pipeline fills
      random_phase(0, 0, 60, 275);
      random_phase(49, 0, 0, 275);
      random_phase(0, 49, 0, 275);
      random_phase(12, 12, 0, 275);

      repeat (10)
         @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

/* segment_intersection_test.f */
rtl/sit_pkg.sv
rtl/sit_front.sv
rtl/sit_sum.sv
rtl/sit_decide.sv
rtl/segment_intersection_test.sv
sim/segment_intersection_test_tb.sv
